/* rtl/core/lr_pkg.sv */
// ----------------------------------------------------------------------------
// lr_pkg
// Shared widths, register indexes, reset values and controller/datapath
// command and status types for the line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

    // payload widths
    localparam int COORD_W    = 6;   // input coordinates and output row
    localparam int XPOS_W     = 7;   // output column, reaches 64 on a zero-length line
    localparam int DIM_W      = 7;   // frame width and height registers
    localparam int ADDR_W     = 12;  // frame word address
    localparam int COLOR_W    = 32;  // packed RGBA8
    localparam int ERR_W      = 10;  // signed error term

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_COLOR  = 2'd2;

    // reset values and default frame limit
    localparam int FRAME_DIM_DEF = 64;
    localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 7'd64;
    localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 7'd64;
    localparam logic [COLOR_W-1:0] RST_BRUSH_COLOR  = 32'hFFFF_FFFF;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture endpoints of a new line
        logic setup;  // derive extents, steps and error term
        logic step;   // emit one pixel and advance
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;      // current pixel is the final one of the line
        logic out_free;  // output register can take a pixel this cycle
    } t_dp_status;

endpackage

`default_nettype wire

/* rtl/core/lr_datapath.sv */
// ----------------------------------------------------------------------------
// lr_datapath
// Configuration registers, Bresenham stepping registers and the output
// register with address generation and clipping.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_datapath
    import lr_pkg::*;
#(
    parameter int FRAME_DIM = FRAME_DIM_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // configuration
    input  wire                    i_cfg_valid,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    // line endpoints
    input  wire  [COORD_W-1:0]     i_start_x,
    input  wire  [COORD_W-1:0]     i_start_y,
    input  wire  [COORD_W-1:0]     i_end_x,
    input  wire  [COORD_W-1:0]     i_end_y,
    // control
    input  wire t_dp_cmd           i_cmd,
    output t_dp_status             o_status,
    // pixel output
    input  wire                    i_out_stall,
    output logic                   o_out_valid,
    output logic [XPOS_W-1:0]      o_pixel_x,
    output logic [COORD_W-1:0]     o_pixel_y,
    output logic [ADDR_W-1:0]      o_pixel_address,
    output logic [COLOR_W-1:0]     o_pixel_color,
    output logic                   o_visible,
    output logic                   o_last_pixel
);

    localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(FRAME_DIM);

    // configuration registers
    logic [DIM_W-1:0]   r_frame_width;
    logic [DIM_W-1:0]   r_frame_height;
    logic [COLOR_W-1:0] r_brush_color;

    // stepping registers
    logic [XPOS_W-1:0]        r_x;
    logic [COORD_W-1:0]       r_y;
    logic [COORD_W-1:0]       r_x1;
    logic [COORD_W-1:0]       r_y1;
    logic [XPOS_W-1:0]        r_x_inc;
    logic [COORD_W-1:0]       r_y_inc;
    logic                     r_steep;
    logic signed [ERR_W-1:0]  r_e;
    logic signed [ERR_W-1:0]  r_e_inc_a;
    logic signed [ERR_W-1:0]  r_e_inc_b;
    logic [XPOS_W-1:0]        r_count;

    // output register
    logic                r_out_valid;
    logic [XPOS_W-1:0]   r_pix_x;
    logic [COORD_W-1:0]  r_pix_y;
    logic [ADDR_W-1:0]   r_pix_addr;
    logic [COLOR_W-1:0]  r_pix_color;
    logic                r_pix_vis;
    logic                r_pix_last;

    // setup arithmetic
    logic                     zero_len;
    logic [XPOS_W-1:0]        x0_adj;
    logic signed [XPOS_W:0]   ddx;
    logic signed [COORD_W:0]  ddy;
    logic [XPOS_W-1:0]        adx;
    logic [XPOS_W-1:0]        ady;
    logic                     steep;
    logic [XPOS_W-1:0]        major;
    logic [XPOS_W-1:0]        minor;
    logic [ERR_W-1:0]         two_minor;
    logic [ERR_W-1:0]         two_major;

    // pixel arithmetic
    logic [DIM_W-1:0]     sat_w;
    logic [DIM_W-1:0]     sat_h;
    logic                 vis;
    logic [DIM_W-1:0]     row_flip;
    logic [2*DIM_W-1:0]   row_base;
    logic [2*DIM_W-1:0]   addr_sum;
    logic                 e_ge;
    logic                 move_x;
    logic                 move_y;
    logic                 out_free;

    // a zero-length line starts one column to the right
    assign zero_len = (i_start_x == i_end_x) && (i_start_y == i_end_y);
    assign x0_adj   = {1'b0, i_start_x} + (zero_len ? 7'd1 : 7'd0);

    // extents and major axis
    assign ddx   = $signed({2'b00, r_x1}) - $signed({1'b0, r_x});
    assign ddy   = $signed({1'b0, r_y1}) - $signed({1'b0, r_y});
    assign adx   = ddx[XPOS_W] ? XPOS_W'(-ddx) : ddx[XPOS_W-1:0];
    assign ady   = ddy[COORD_W] ? XPOS_W'(-ddy) : XPOS_W'(ddy);
    assign steep = ady > adx;
    assign major = steep ? ady : adx;
    assign minor = steep ? adx : ady;
    assign two_minor = ERR_W'({minor, 1'b0});
    assign two_major = ERR_W'({major, 1'b0});

    // frame size clipped to the supported limit
    assign sat_w = (r_frame_width  > DIM_LIMIT) ? DIM_LIMIT : r_frame_width;
    assign sat_h = (r_frame_height > DIM_LIMIT) ? DIM_LIMIT : r_frame_height;

    // clipping and y-flipped word address
    assign vis      = (r_x < sat_w) && ({1'b0, r_y} < sat_h);
    assign row_flip = sat_h - 7'd1 - {1'b0, r_y};
    assign row_base = row_flip * sat_w;
    assign addr_sum = row_base + {{DIM_W{1'b0}}, r_x};

    // minor axis moves when the error term is non-negative
    assign e_ge   = !r_e[ERR_W-1];
    assign move_x = r_steep ? e_ge : 1'b1;
    assign move_y = r_steep ? 1'b1 : e_ge;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_status = '{last: (r_count == '0), out_free: out_free};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_brush_color  <= RST_BRUSH_COLOR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                CFG_BRUSH_COLOR:  r_brush_color  <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // endpoint capture, setup and stepping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= x0_adj;
            r_y  <= i_start_y;
            r_x1 <= i_end_x;
            r_y1 <= i_end_y;
        end else if (i_cmd.setup) begin
            r_steep   <= steep;
            r_count   <= major;
            r_x_inc   <= ddx[XPOS_W] ? {XPOS_W{1'b1}}
                       : ((ddx == '0) ? '0 : XPOS_W'(1));
            r_y_inc   <= ddy[COORD_W] ? {COORD_W{1'b1}}
                       : ((ddy == '0) ? '0 : COORD_W'(1));
            r_e       <= $signed(two_minor - ERR_W'(major));
            r_e_inc_a <= $signed(two_minor);
            r_e_inc_b <= $signed(two_minor - two_major);
        end else if (i_cmd.step) begin
            r_x     <= r_x + (move_x ? r_x_inc : '0);
            r_y     <= r_y + (move_y ? r_y_inc : '0);
            r_e     <= r_e + (e_ge ? r_e_inc_b : r_e_inc_a);
            r_count <= r_count - 7'd1;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_pix_x     <= r_x;
            r_pix_y     <= r_y;
            r_pix_addr  <= vis ? addr_sum[ADDR_W-1:0] : '0;
            r_pix_color <= r_brush_color;
            r_pix_vis   <= vis;
            r_pix_last  <= (r_count == '0);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_x       = r_pix_x;
    assign o_pixel_y       = r_pix_y;
    assign o_pixel_address = r_pix_addr;
    assign o_pixel_color   = r_pix_color;
    assign o_visible       = r_pix_vis;
    assign o_last_pixel    = r_pix_last;

endmodule

`default_nettype wire

/* rtl/core/lr_ctrl.sv */
// ----------------------------------------------------------------------------
// lr_ctrl
// Sequencer for one line: accept, setup, then one pixel per free output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_ctrl
    import lr_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire t_dp_status  i_status,
    output t_dp_cmd          o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_RUN;
            end
            S_RUN: begin
                if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

/* rtl/core/line_rasterizer_top.sv */
// ----------------------------------------------------------------------------
// line_rasterizer_top
// Bresenham line rasterizer: one line command in, its pixels out in order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one line per beat: start and
//   end points in whole pixels. Output channel (o_out_valid / i_out_stall)
//   gives one pixel per beat with coordinates, y-flipped word address, brush
//   color, visible flag and a last marker on the final pixel.
//   Config channel (i_cfg_valid / o_cfg_ready) writes frame width, frame
//   height and brush color; write it only while no line is in flight.
//   The first pixel passes the load, setup and step commands and then the output
//   register before it is valid. A line is loaded, set up, then stepped at one
//   pixel a cycle from a single stepping unit without back-pressure; the input
//   opens for the next line once its last pixel enters the output register,
//   while that pixel may still be waiting.
//   A stalled output holds its beat and freezes stepping until it is taken.
//   Reset clears the sequencer and output valid and restores a 64 x 64 frame
//   with a white brush; o_cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer_top
    import lr_pkg::*;
#(
    parameter int FRAME_DIM = FRAME_DIM_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // configuration
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    // line input
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire  [COORD_W-1:0]     i_start_x,
    input  wire  [COORD_W-1:0]     i_start_y,
    input  wire  [COORD_W-1:0]     i_end_x,
    input  wire  [COORD_W-1:0]     i_end_y,
    // pixel output
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output logic [XPOS_W-1:0]      o_pixel_x,
    output logic [COORD_W-1:0]     o_pixel_y,
    output logic [ADDR_W-1:0]      o_pixel_address,
    output logic [COLOR_W-1:0]     o_pixel_color,
    output logic                   o_visible,
    output logic                   o_last_pixel
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    // sequencer
    lr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // stepping and pixel datapath
    lr_datapath #(
        .FRAME_DIM (FRAME_DIM)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_visible       (o_visible),
        .o_last_pixel    (o_last_pixel)
    );

endmodule

`default_nettype wire

/* rtl/core/lr_checker.sv */
// ----------------------------------------------------------------------------
// lr_checker
// Port-level checks on the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_checker
    import lr_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_stall,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input wire [XPOS_W-1:0]     o_pixel_x,
    input wire [COORD_W-1:0]    o_pixel_y,
    input wire [ADDR_W-1:0]     o_pixel_address,
    input wire [COLOR_W-1:0]    o_pixel_color,
    input wire                  o_visible,
    input wire                  o_last_pixel
);

    // reset leaves the block empty and ready for a line
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

    // an accepted line keeps the input closed while it is set up
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after a line beat");

    // a stalled pixel beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_x)
            && $stable(o_pixel_y) && $stable(o_pixel_address)
            && $stable(o_pixel_color) && $stable(o_visible)
            && $stable(o_last_pixel))
        else $error("stalled pixel beat changed");

    // clipped pixels carry a zero address
    a_invisible_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_visible |-> o_pixel_address == '0)
        else $error("invisible pixel with nonzero address");

    // a visible pixel lies inside the largest frame
    a_visible_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_visible |-> o_pixel_x < XPOS_W'(FRAME_DIM_DEF))
        else $error("visible pixel outside the frame");

endmodule

bind line_rasterizer_top lr_checker u_lr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_pixel_x       (o_pixel_x),
    .o_pixel_y       (o_pixel_y),
    .o_pixel_address (o_pixel_address),
    .o_pixel_color   (o_pixel_color),
    .o_visible       (o_visible),
    .o_last_pixel    (o_last_pixel)
);

`default_nettype wire
